// ===== rtl/irf_pkg.sv =====
// irf_pkg: shared types and constants of the infrared range filter
// controller state, command bundle, field widths and register indexes
// no dependencies
`timescale 1ns / 1ps

package irf_pkg;

  localparam int FRAC_BITS  = 16;

  localparam int RAW_W      = 16;
  localparam int SAMP_W     = 15;
  localparam int HEIGHT_W   = 32;
  localparam int WGT_W      = 17;
  localparam int OFF_W      = 32;
  localparam int SCALE_W    = 40;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 40;

  localparam int DIV_STEPS  = SCALE_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam int unsigned WGT_ONE = 32'd1 << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_OFFSET  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FLOOR     = CFG_IDX_W'(3);

  localparam logic [WGT_W-1:0]   RST_SMOOTHING_WEIGHT = '0;
  localparam logic [OFF_W-1:0]   RST_DISTANCE_OFFSET  = OFF_W'(65536);
  localparam logic [SCALE_W-1:0] RST_DISTANCE_SCALE   = '0;
  localparam logic [SAMP_W-1:0]  RST_SAMPLE_FLOOR     = SAMP_W'(2000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POST,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } irf_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic post;
    logic diff;
    logic mul;
    logic acc;
    logic publish;
  } irf_cmd_t;

endpackage

// ===== rtl/ir_range_inverse_ema_filter.sv =====
// ir_range_inverse_ema_filter: top level of the infrared range filter
// holds the configuration registers and the result register
// depends on irf_pkg, irf_ctrl, irf_dp
`timescale 1ns / 1ps

//  channel   direction  handshake          payload
//  in_       input      in_valid/in_stall  raw_sample (16)
//  out_      output     out_valid/out_stall smoothed_height (32 s), clamped_sample (15)
//  cfg_      input      cfg_wr_en          cfg_index (4), cfg_wdata (40)
//
//  an item runs alone, with the input stalled, until the next acceptance: the accepting
//  cycle loads the operands, 40 steps of the one-bit-per-cycle restoring divider,
//  then offset add, difference, multiply and accumulate, plus the hand-off, which
//  writes the result register
//  the next item is accepted in the cycle after the hand-off has filled the output
//  register, even if the downstream side still stalls it; a finished item waits in
//  the hand-off state, with the input stalled, while the output register is stalled
//  rst_n is synchronous, active low; it clears the filter state and loads
//  the register reset values

module ir_range_inverse_ema_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [irf_pkg::RAW_W-1:0]      in_raw_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [irf_pkg::HEIGHT_W-1:0]   out_smoothed_height,
  output logic [irf_pkg::SAMP_W-1:0]     out_clamped_sample,
  input  logic                           cfg_wr_en,
  input  logic [irf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import irf_pkg::*;

  // configuration registers
  logic [WGT_W-1:0]   weight_r;
  logic [OFF_W-1:0]   offset_r;
  logic [SCALE_W-1:0] scale_r;
  logic [SAMP_W-1:0]  floor_r;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [HEIGHT_W-1:0] out_height_r;
  logic [SAMP_W-1:0]   out_samp_r;

  irf_cmd_t            cmd;
  logic                out_free;
  logic [HEIGHT_W-1:0] filt;
  logic [SAMP_W-1:0]   samp;

  // writes to an index past the last register fall through untouched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= RST_SMOOTHING_WEIGHT;
      offset_r <= RST_DISTANCE_OFFSET;
      scale_r  <= RST_DISTANCE_SCALE;
      floor_r  <= RST_SAMPLE_FLOOR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SMOOTHING_WEIGHT: weight_r <= cfg_wdata[WGT_W-1:0];
        REG_DISTANCE_OFFSET:  offset_r <= cfg_wdata[OFF_W-1:0];
        REG_DISTANCE_SCALE:   scale_r  <= cfg_wdata[SCALE_W-1:0];
        REG_SAMPLE_FLOOR:     floor_r  <= cfg_wdata[SAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // the result register can take a new item when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  irf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .cmd      (cmd)
  );

  irf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .raw_sample       (in_raw_sample),
    .smoothing_weight (weight_r),
    .distance_offset  (offset_r),
    .distance_scale   (scale_r),
    .sample_floor     (floor_r),
    .filt_o           (filt),
    .samp_o           (samp)
  );

  // valid is set by a hand-off and cleared once downstream takes the item
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_height_r <= filt;
      out_samp_r   <= samp;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_smoothed_height = out_height_r;
  assign out_clamped_sample  = out_samp_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.publish && out_valid_r && out_stall))
    else $error("ir_range_inverse_ema_filter: result overwritten while stalled");

  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("ir_range_inverse_ema_filter: stalled result dropped");

  a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(out_height_r) && $stable(out_samp_r)))
    else $error("ir_range_inverse_ema_filter: stalled payload changed");

endmodule

// ===== rtl/irf_ctrl.sv =====
// irf_ctrl: sequencer of the infrared range filter
// walks one item through load, divide, offset, difference, multiply, accumulate
// depends on irf_pkg
`timescale 1ns / 1ps

module irf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_free,
  output irf_pkg::irf_cmd_t cmd
);
  import irf_pkg::*;

  irf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             div_last;

  assign div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_last) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_POST: cmd.post     = 1'b1;
      ST_DIFF: cmd.diff     = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_ACC:  cmd.acc      = 1'b1;
      ST_DONE: cmd.publish  = out_free;
      default: cmd = '0;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("irf_ctrl: more than one command at once");

  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_DIV && cnt_r == '0))
    else $error("irf_ctrl: load did not start the divider");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_last) |=> (state_r == ST_POST))
    else $error("irf_ctrl: divide phase ran past its last step");

endmodule

// ===== rtl/irf_dp.sv =====
// irf_dp: datapath of the infrared range filter
// clamp, restoring divider, offset add, smoothing multiply and accumulator
// depends on irf_pkg
`timescale 1ns / 1ps

module irf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irf_pkg::irf_cmd_t             cmd,
  input  logic [irf_pkg::RAW_W-1:0]     raw_sample,
  input  logic [irf_pkg::WGT_W-1:0]     smoothing_weight,
  input  logic [irf_pkg::OFF_W-1:0]     distance_offset,
  input  logic [irf_pkg::SCALE_W-1:0]   distance_scale,
  input  logic [irf_pkg::SAMP_W-1:0]    sample_floor,
  output logic [irf_pkg::HEIGHT_W-1:0]  filt_o,
  output logic [irf_pkg::SAMP_W-1:0]    samp_o
);
  import irf_pkg::*;

  localparam int QS_W   = SCALE_W + 1;
  localparam int SUM_W  = QS_W + 1;
  localparam int DIFF_W = HEIGHT_W + 1;
  localparam int PROD_W = DIFF_W + WGT_W + 1;
  localparam int STEP_W = PROD_W - FRAC_BITS;
  localparam int ACC_W  = STEP_W + 1;

  logic [SAMP_W-1:0]          samp_r, samp_nxt;
  logic [SAMP_W-1:0]          dvs_r, dvs_nxt;
  logic [SAMP_W-1:0]          rem_r, rem_nxt;
  logic [SCALE_W-1:0]         quo_r, quo_nxt;
  logic                       neg_r, neg_nxt;
  logic [WGT_W-1:0]           wgt_r, wgt_nxt;
  logic signed [HEIGHT_W-1:0] raw_dist_r, raw_dist_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [HEIGHT_W-1:0] filt_r, filt_nxt;

  logic [SAMP_W-1:0]          clamped;
  logic [SAMP_W:0]            rem_shift;
  logic [SAMP_W:0]            trial;
  logic signed [QS_W-1:0]     qs;
  logic signed [SUM_W-1:0]    off_sum;
  logic signed [STEP_W-1:0]   step;
  logic signed [ACC_W-1:0]    acc_sum;

  // negative readings and readings under the floor are raised to it
  assign clamped = (raw_sample[RAW_W-1] || (raw_sample[SAMP_W-1:0] < sample_floor)) ?
                   sample_floor : raw_sample[SAMP_W-1:0];

  assign rem_shift = {rem_r, quo_r[SCALE_W-1]};
  assign trial     = rem_shift - {1'b0, dvs_r};

  assign qs      = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign off_sum = {qs[QS_W-1], qs} +
                   {{(SUM_W - OFF_W){distance_offset[OFF_W-1]}}, distance_offset};

  assign step    = prod_r[PROD_W-1:FRAC_BITS];
  assign acc_sum = {{(ACC_W - HEIGHT_W){filt_r[HEIGHT_W-1]}}, filt_r} + {step[STEP_W-1], step};

  always_comb begin
    samp_nxt     = samp_r;
    dvs_nxt      = dvs_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    neg_nxt      = neg_r;
    wgt_nxt      = wgt_r;
    raw_dist_nxt = raw_dist_r;
    diff_nxt     = diff_r;
    prod_nxt     = prod_r;
    filt_nxt     = filt_r;
    if (cmd.load) begin
      samp_nxt = clamped;
      dvs_nxt  = (clamped == '0) ? SAMP_W'(1) : clamped;
      rem_nxt  = '0;
      neg_nxt  = distance_scale[SCALE_W-1];
      quo_nxt  = distance_scale[SCALE_W-1] ? (~distance_scale + SCALE_W'(1)) : distance_scale;
      // weights above one act as one
      if ({{(32 - WGT_W){1'b0}}, smoothing_weight} > WGT_ONE) begin
        wgt_nxt = WGT_W'(WGT_ONE);
      end else begin
        wgt_nxt = smoothing_weight;
      end
    end
    if (cmd.div_step) begin
      if (!trial[SAMP_W]) begin
        rem_nxt = trial[SAMP_W-1:0];
        quo_nxt = {quo_r[SCALE_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[SAMP_W-1:0];
        quo_nxt = {quo_r[SCALE_W-2:0], 1'b0};
      end
    end
    if (cmd.post) begin
      if (off_sum[SUM_W-1:HEIGHT_W-1] != {(SUM_W - HEIGHT_W + 1){off_sum[SUM_W-1]}}) begin
        raw_dist_nxt = off_sum[SUM_W-1] ? {1'b1, {(HEIGHT_W-1){1'b0}}}
                                        : {1'b0, {(HEIGHT_W-1){1'b1}}};
      end else begin
        raw_dist_nxt = off_sum[HEIGHT_W-1:0];
      end
    end
    if (cmd.diff) begin
      diff_nxt = {raw_dist_r[HEIGHT_W-1], raw_dist_r} - {filt_r[HEIGHT_W-1], filt_r};
    end
    if (cmd.mul) begin
      // both operands sign extended to the full product width
      prod_nxt = PROD_W'(diff_r) * PROD_W'($signed({1'b0, wgt_r}));
    end
    if (cmd.acc) begin
      if (acc_sum[ACC_W-1:HEIGHT_W-1] != {(ACC_W - HEIGHT_W + 1){acc_sum[ACC_W-1]}}) begin
        filt_nxt = acc_sum[ACC_W-1] ? {1'b1, {(HEIGHT_W-1){1'b0}}}
                                    : {1'b0, {(HEIGHT_W-1){1'b1}}};
      end else begin
        filt_nxt = acc_sum[HEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    samp_r     <= samp_nxt;
    dvs_r      <= dvs_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    wgt_r      <= wgt_nxt;
    raw_dist_r <= raw_dist_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else begin
      filt_r <= filt_nxt;
    end
  end

  assign filt_o = filt_r;
  assign samp_o = samp_r;

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the infrared range filter
// predicts each item's smoothed height and clamped sample, checks every result in order
// depends on irf_pkg and ir_range_inverse_ema_filter
`timescale 1ns / 1ps

module tb_top;
  import irf_pkg::*;

  localparam int     QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
  localparam int     LONG_HOLD   = 200;    // receiver hold-off that backs the block up
  localparam int     TAIL_WAIT   = 60;     // block latency plus margin
  localparam int     MAX_REPORTS = 60;
  localparam longint HEIGHT_MAX  = 64'sd2147483647;
  localparam longint HEIGHT_MIN  = -64'sd2147483648;

  // indexes past the four registers, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(15);

  typedef struct {
    logic [HEIGHT_W-1:0] height;
    logic [SAMP_W-1:0]   clamped;
  } reading_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [RAW_W-1:0]      in_raw_sample = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [HEIGHT_W-1:0]   out_smoothed_height;
  logic [SAMP_W-1:0]     out_clamped_sample;
  logic                  cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  // shadow copy of the filter registers and state
  logic [WGT_W-1:0]   weight_reg;
  logic [OFF_W-1:0]   offset_reg;
  logic [SCALE_W-1:0] scale_reg;
  logic [SAMP_W-1:0]  floor_reg;
  longint             est_distance;

  logic [RAW_W-1:0] sample_backlog[$];   // items waiting for the sender
  reading_t         due_readings[$];     // predicted results, oldest first

  logic in_took = 1'b0;
  int   quiet_cycles   = 0;
  int   mismatch_count = 0;
  int   result_count   = 0;

  // idling controls, set per phase from the sequence below
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;

  ir_range_inverse_ema_filter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_raw_sample       (in_raw_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_smoothed_height (out_smoothed_height),
    .out_clamped_sample  (out_clamped_sample),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clip_s32(longint v);
    if (v > HEIGHT_MAX) return HEIGHT_MAX;
    if (v < HEIGHT_MIN) return HEIGHT_MIN;
    return v;
  endfunction

  // idle percentage for one side in a random phase
  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 35;
    endcase
  endfunction

  // one filter step: clamp, divide, add offset, then move the estimate toward it
  function automatic reading_t track_distance(logic [RAW_W-1:0] raw);
    reading_t   r;
    logic [SAMP_W-1:0] clamped;
    longint     divisor;
    longint     quotient;
    longint     target;
    longint     wgt;
    longint     step;
    // negative readings and readings under the floor are lifted to the floor
    if (raw[RAW_W-1] || raw < {1'b0, floor_reg})
      clamped = floor_reg;
    else
      clamped = raw[SAMP_W-1:0];
    // a zero sample with a zero floor divides by one
    divisor  = (clamped == '0) ? 64'sd1 : longint'(clamped);
    // signed division truncates toward zero
    quotient = longint'($signed(scale_reg)) / divisor;
    target   = clip_s32(quotient + longint'($signed(offset_reg)));
    // weights past one behave as one
    wgt = (longint'(weight_reg) > longint'(WGT_ONE)) ? longint'(WGT_ONE) : longint'(weight_reg);
    // arithmetic shift rounds toward minus infinity
    step = ((target - est_distance) * wgt) >>> FRAC_BITS;
    est_distance = clip_s32(est_distance + step);
    r.height  = est_distance[HEIGHT_W-1:0];
    r.clamped = clamped;
    return r;
  endfunction

  task automatic report_error(string msg);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] error: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // predictor, register shadow and result checks, all on the rising edge
  always @(posedge clk) begin : result_checker
    reading_t want;
    if (!rst_n) begin
      weight_reg   = RST_SMOOTHING_WEIGHT;
      offset_reg   = RST_DISTANCE_OFFSET;
      scale_reg    = RST_DISTANCE_SCALE;
      floor_reg    = RST_SAMPLE_FLOOR;
      est_distance = 0;
      in_took      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SMOOTHING_WEIGHT: weight_reg = cfg_wdata[WGT_W-1:0];
          REG_DISTANCE_OFFSET:  offset_reg = cfg_wdata[OFF_W-1:0];
          REG_DISTANCE_SCALE:   scale_reg  = cfg_wdata[SCALE_W-1:0];
          REG_SAMPLE_FLOOR:     floor_reg  = cfg_wdata[SAMP_W-1:0];
          default: ;
        endcase
      end
      // results leave first: an item accepted this edge cannot be the one returned
      if (out_valid && !out_stall) begin
        if (due_readings.size() == 0) begin
          report_error($sformatf("unexpected result height %0d clamped %0d",
                                 $signed(out_smoothed_height), out_clamped_sample));
        end else begin
          want = due_readings.pop_front();
          if (out_smoothed_height !== want.height)
            report_error($sformatf("result %0d smoothed_height got %0d expected %0d",
                                   result_count, $signed(out_smoothed_height),
                                   $signed(want.height)));
          if (out_clamped_sample !== want.clamped)
            report_error($sformatf("result %0d clamped_sample got %0d expected %0d",
                                   result_count, out_clamped_sample, want.clamped));
        end
        result_count++;
      end
      if (in_valid && !in_stall)
        due_readings.push_back(track_distance(in_raw_sample));
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      in_took <= in_valid && !in_stall;
    end
  end

  // sender: holds a stalled item, otherwise pops the next one or idles for a burst
  always @(negedge clk) begin : sample_driver
    int               gap_left;
    logic             nxt_valid;
    logic [RAW_W-1:0] nxt_sample;
    nxt_valid  = in_valid;
    nxt_sample = in_raw_sample;
    if (!(in_valid && !in_took)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_backlog.size() != 0) begin
        if ($urandom_range(0, 99) < send_idle_pct) begin
          gap_left = $urandom_range(0, 16);   // idle now and while gap_left counts down
        end else begin
          nxt_valid  = 1'b1;
          nxt_sample = sample_backlog.pop_front();
        end
      end
    end
    in_valid      <= nxt_valid;
    in_raw_sample <= nxt_sample;
  end

  // receiver: random stall bursts, plus a long hold-off whenever one is asked for
  always @(negedge clk) begin : height_sink
    int   hold_left;
    int   holds_done;
    int   burst_left;
    logic nxt_stall;
    if (hold_left > 0) begin
      nxt_stall = 1'b1;
      hold_left--;
    end else if (holds_done < holds_asked) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      nxt_stall = 1'b1;
    end else if (burst_left > 0) begin
      nxt_stall = 1'b1;
      burst_left--;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      nxt_stall  = 1'b1;
      burst_left = $urandom_range(0, 16);
    end else begin
      nxt_stall = 1'b0;
    end
    out_stall <= nxt_stall;
  end

  // a stuck handshake ends the run
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // block is idle once every item went in and every result came out
  // polled on the rising edge, where the sender's outputs are settled
  task automatic wait_idle();
    while (sample_backlog.size() != 0 || in_valid || due_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_filter(logic [WGT_W-1:0] wgt, logic [OFF_W-1:0] off,
                                logic [SCALE_W-1:0] scale, logic [SAMP_W-1:0] flr);
    wait_idle();
    write_reg(REG_SMOOTHING_WEIGHT, CFG_DATA_W'(wgt));
    write_reg(REG_DISTANCE_OFFSET,  {{(CFG_DATA_W-OFF_W){off[OFF_W-1]}}, off});
    write_reg(REG_DISTANCE_SCALE,   scale);
    write_reg(REG_SAMPLE_FLOOR,     CFG_DATA_W'(flr));
    @(posedge clk);
  endtask

  initial begin : sequencer
    int                 phase;
    int                 n;
    int                 near;
    logic [WGT_W-1:0]   wgt;
    logic [OFF_W-1:0]   off;
    logic [SCALE_W-1:0] scale;
    logic [SAMP_W-1:0]  flr;
    logic [RAW_W-1:0]   raw;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, weight zero keeps the height at zero
    send_idle_pct = 10;
    recv_idle_pct = 10;
    sample_backlog.push_back(16'h0000);
    sample_backlog.push_back(16'hFFFF);
    sample_backlog.push_back(16'h8000);
    sample_backlog.push_back(16'h7FFF);
    sample_backlog.push_back(16'd1999);
    sample_backlog.push_back(16'd2000);

    // zero floor: a zero sample divides by one, huge quotients saturate high
    program_filter(WGT_W'(WGT_ONE), 32'h0, 40'h7F_FFFF_FFFF, 15'd0);
    sample_backlog.push_back(16'h0000);
    sample_backlog.push_back(16'h0001);
    sample_backlog.push_back(16'h8000);
    sample_backlog.push_back(16'h7FFF);
    sample_backlog.push_back(16'h0002);

    // weight above one, most negative offset and scale, highest floor
    program_filter(17'h1FFFF, 32'h8000_0000, 40'h80_0000_0000, 15'h7FFF);
    write_reg(REG_UNUSED_LO, {CFG_DATA_W{1'b1}});
    write_reg(REG_UNUSED_HI, CFG_DATA_W'(40'h12_3456_789A));
    @(posedge clk);
    sample_backlog.push_back(16'h0000);
    sample_backlog.push_back(16'h7FFF);
    sample_backlog.push_back(16'hFFFF);
    sample_backlog.push_back(16'h7FFE);

    // tiny weight from the negative rail, offset sum saturating high
    program_filter(17'd1, 32'h7FFF_FFFF, 40'd1000000, 15'd100);
    sample_backlog.push_back(16'h1234);
    sample_backlog.push_back(16'h0001);
    sample_backlog.push_back(16'hFFFF);
    sample_backlog.push_back(16'h4000);

    // negative quotient truncation and floor rounding of a halved step
    program_filter(17'd32768, -32'sd65536, -40'sd7, 15'd3);
    sample_backlog.push_back(16'd3);
    sample_backlog.push_back(16'd4);
    sample_backlog.push_back(16'd2);
    sample_backlog.push_back(16'd5);

    // random phases, the last one runs with no idling on either side
    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0:       wgt = '0;
        1:       wgt = WGT_W'(WGT_ONE);
        2:       wgt = '1;
        3:       wgt = WGT_W'($urandom);
        default: wgt = WGT_W'($urandom_range(1, WGT_ONE));
      endcase
      case ($urandom_range(0, 4))
        0:       off = $urandom;
        1:       off = 32'h7FFF_FFFF;
        2:       off = 32'h8000_0000;
        default: off = OFF_W'(int'($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
      endcase
      case ($urandom_range(0, 5))
        0:       scale = {8'($urandom), 32'($urandom)};
        1:       scale = 40'h7F_FFFF_FFFF;
        2:       scale = 40'h80_0000_0000;
        3:       scale = -{5'd0, 3'($urandom), 32'($urandom)};
        default: scale = {5'd0, 3'($urandom), 32'($urandom)};   // sensor-like curve
      endcase
      case ($urandom_range(0, 5))
        0:       flr = '0;
        1:       flr = '1;
        2:       flr = SAMP_W'(2000);
        3:       flr = SAMP_W'($urandom);
        default: flr = SAMP_W'($urandom_range(0, 4000));
      endcase
      program_filter(wgt, off, scale, flr);
      if (phase % 3 == 1) begin
        write_reg(REG_UNUSED_LO + CFG_IDX_W'($urandom_range(0, 11)),
                  {8'($urandom), 32'($urandom)});
        @(posedge clk);
      end
      if (phase == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = pick_idle_pct();
        recv_idle_pct = pick_idle_pct();
      end
      for (n = 0; n < 48; n++) begin
        case ($urandom_range(0, 7))
          0, 1: raw = RAW_W'($urandom);
          2:    raw = 16'h8000 | RAW_W'($urandom_range(0, 16'h7FFF));
          3: begin
            near = int'(flr) + int'($urandom_range(0, 4)) - 2;
            raw  = (near < 0) ? '0 : RAW_W'(near);
          end
          4:    raw = '0;
          5:    raw = RAW_W'($urandom_range(2000, 26000));
          6:    raw = RAW_W'($urandom_range(0, 3));
          default: raw = $urandom_range(0, 1) ? 16'h7FFF : 16'hFFFF;
        endcase
        sample_backlog.push_back(raw);
      end
      // back the block up while the sender keeps offering
      if (phase == 2) begin
        @(posedge clk);
        holds_asked++;
      end
    end

    wait_idle();
    repeat (TAIL_WAIT) @(posedge clk);
    if (due_readings.size() != 0)
      report_error($sformatf("%0d results never arrived", due_readings.size()));
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
